FILE: rtl/tmcbs_pkg.sv
// ----------------------------------------------------------------------------
// tmcbs_pkg
// Shared widths and constants for the texture mip chain byte size unit.
// ----------------------------------------------------------------------------
package tmcbs_pkg;

    localparam int DIM_W     = 15;  // width and height
    localparam int DEPTH_W   = 12;
    localparam int LEVEL_W   = 5;
    localparam int SLICE_W   = 12;
    localparam int BBYTES_W  = 5;
    localparam int BLOCK_W   = 4;
    localparam int PBYTES_W  = 5;
    localparam int TOTAL_W   = 61;

    // shared multiplier operand and product widths
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 17;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    // shared divider: dividend holds dim + block size - 1
    localparam int DIV_W     = DIM_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // slice count times face count
    localparam int SCALE_W   = 15;
    localparam int CUBE_FACES = 6;

endpackage

FILE: rtl/texture_mip_chain_byte_size_unit.sv
// ----------------------------------------------------------------------------
// texture_mip_chain_byte_size_unit
// Total memory bytes of a texture over all mip levels, slices and cube faces.
// ----------------------------------------------------------------------------
// One request at a time: s_ready is high only while the unit is idle, and the
// result is held on the m_ channel until taken. All arithmetic runs through one
// shared 32x17 multiplier and one radix-2 restoring divider under a small
// sequencer. For every level (a level count of zero counts as one), the unit
// runs three multiply steps and an accumulate; a compressed format first runs
// two divisions per level for the block counts. After the last level the sum
// is scaled by the slice count and the cube faces in two partial products.
module texture_mip_chain_byte_size_unit
    import tmcbs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [DIM_W-1:0]    s_tex_width,
    input  logic [DIM_W-1:0]    s_tex_height,
    input  logic [DEPTH_W-1:0]  s_tex_depth,
    input  logic [LEVEL_W-1:0]  s_level_count,
    input  logic                s_is_cube,
    input  logic [SLICE_W-1:0]  s_array_slices,
    input  logic [BBYTES_W-1:0] s_block_bytes,
    input  logic [BLOCK_W-1:0]  s_block_w,
    input  logic [BLOCK_W-1:0]  s_block_h,
    input  logic [PBYTES_W-1:0] s_pixel_bytes,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [TOTAL_W-1:0]  m_total_bytes
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_DIV_X,
        ST_DIV_Y,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_ACC,
        ST_FIN_K,
        ST_FIN_LO,
        ST_FIN_HI,
        ST_FIN_ADD,
        ST_DONE
    } state_t;

    state_t                state_reg;

    logic [DIM_W-1:0]      cur_w_reg;
    logic [DIM_W-1:0]      cur_h_reg;
    logic [DEPTH_W-1:0]    cur_d_reg;
    logic [LEVEL_W-1:0]    levels_reg;
    logic [LEVEL_W-1:0]    lv_reg;
    logic                  is_cube_reg;
    logic [SLICE_W-1:0]    slices_reg;
    logic [BBYTES_W-1:0]   bbytes_reg;
    logic [BLOCK_W-1:0]    bw_reg;
    logic [BLOCK_W-1:0]    bh_reg;
    logic [PBYTES_W-1:0]   pbytes_reg;

    logic [DIV_W-1:0]      div_quo_reg;
    logic [BLOCK_W-1:0]    div_rem_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [DIV_W-1:0]      bx_reg;
    logic [DIV_W-1:0]      by_reg;

    logic [MUL_P_W-1:0]    prod_reg;
    logic [2*DIM_W-1:0]    tmp_reg;
    logic [SCALE_W-1:0]    scale_reg;
    logic [TOTAL_W-1:0]    total_reg;

    // effective values: zero dimensions and block sizes count as one
    logic [DIM_W-1:0]      w_eff;
    logic [DIM_W-1:0]      h_eff;
    logic [DEPTH_W-1:0]    d_eff;
    logic [BLOCK_W-1:0]    bw_eff;
    logic [BLOCK_W-1:0]    bh_eff;
    logic [LEVEL_W-1:0]    levels_eff;
    logic [SLICE_W-1:0]    slices_eff;
    logic                  compressed;
    logic                  last_level;

    assign w_eff      = (cur_w_reg == '0) ? DIM_W'(1) : cur_w_reg;
    assign h_eff      = (cur_h_reg == '0) ? DIM_W'(1) : cur_h_reg;
    assign d_eff      = (cur_d_reg == '0) ? DEPTH_W'(1) : cur_d_reg;
    assign bw_eff     = (bw_reg == '0) ? BLOCK_W'(1) : bw_reg;
    assign bh_eff     = (bh_reg == '0) ? BLOCK_W'(1) : bh_reg;
    assign levels_eff = (levels_reg == '0) ? LEVEL_W'(1) : levels_reg;
    assign slices_eff = (slices_reg == '0) ? SLICE_W'(1) : slices_reg;
    assign compressed = (bbytes_reg != '0);
    assign last_level = (lv_reg == levels_eff - LEVEL_W'(1));

    // ceil division dividends
    logic [DIV_W-1:0] div_x_init;
    logic [DIV_W-1:0] div_y_init;

    assign div_x_init = DIV_W'(w_eff) + DIV_W'(bw_eff) - DIV_W'(1);
    assign div_y_init = DIV_W'(h_eff) + DIV_W'(bh_eff) - DIV_W'(1);

    // shared restoring divider step
    logic [BLOCK_W-1:0]  div_divisor;
    logic [BLOCK_W:0]    div_trial;
    logic                div_ge;
    logic [BLOCK_W-1:0]  div_rem_next;
    logic [DIV_W-1:0]    div_quo_next;
    logic                div_last;

    always_comb begin
        div_divisor  = (state_reg == ST_DIV_Y) ? bh_eff : bw_eff;
        div_trial    = {div_rem_reg, div_quo_reg[DIV_W-1]};
        div_ge       = (div_trial >= {1'b0, div_divisor});
        div_rem_next = div_ge ? BLOCK_W'(div_trial - {1'b0, div_divisor})
                              : BLOCK_W'(div_trial);
        div_quo_next = {div_quo_reg[DIV_W-2:0], div_ge};
        div_last     = (div_cnt_reg == DIV_CNT_W'(DIV_W - 1));
    end

    // shared multiplier operand select
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_A: begin
                if (compressed) begin
                    mul_a = MUL_A_W'(bx_reg);
                    mul_b = MUL_B_W'(by_reg);
                end else begin
                    mul_a = MUL_A_W'(w_eff);
                    mul_b = MUL_B_W'(h_eff);
                end
            end
            ST_MUL_B: begin
                mul_a = MUL_A_W'(d_eff);
                mul_b = compressed ? MUL_B_W'(bbytes_reg) : MUL_B_W'(pbytes_reg);
            end
            ST_MUL_C: begin
                mul_a = MUL_A_W'(tmp_reg);
                mul_b = prod_reg[MUL_B_W-1:0];
            end
            ST_FIN_K: begin
                mul_a = MUL_A_W'(slices_eff);
                mul_b = is_cube_reg ? MUL_B_W'(CUBE_FACES) : MUL_B_W'(1);
            end
            ST_FIN_LO: begin
                mul_a = total_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(prod_reg[SCALE_W-1:0]);
            end
            ST_FIN_HI: begin
                mul_a = MUL_A_W'(total_reg[TOTAL_W-1:MUL_A_W]);
                mul_b = MUL_B_W'(scale_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cur_w_reg   <= s_tex_width;
                        cur_h_reg   <= s_tex_height;
                        cur_d_reg   <= s_tex_depth;
                        levels_reg  <= s_level_count;
                        is_cube_reg <= s_is_cube;
                        slices_reg  <= s_array_slices;
                        bbytes_reg  <= s_block_bytes;
                        bw_reg      <= s_block_w;
                        bh_reg      <= s_block_h;
                        pbytes_reg  <= s_pixel_bytes;
                        lv_reg      <= '0;
                        total_reg   <= '0;
                        state_reg   <= ST_LEVEL;
                    end
                end
                ST_LEVEL: begin
                    if (compressed) begin
                        div_quo_reg <= div_x_init;
                        div_rem_reg <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= ST_DIV_X;
                    end else begin
                        state_reg   <= ST_MUL_A;
                    end
                end
                ST_DIV_X: begin
                    if (div_last) begin
                        bx_reg      <= div_quo_next;
                        div_quo_reg <= div_y_init;
                        div_rem_reg <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= ST_DIV_Y;
                    end else begin
                        div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                        div_quo_reg <= div_quo_next;
                        div_rem_reg <= div_rem_next;
                    end
                end
                ST_DIV_Y: begin
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    div_quo_reg <= div_quo_next;
                    div_rem_reg <= div_rem_next;
                    if (div_last) begin
                        by_reg    <= div_quo_next;
                        state_reg <= ST_MUL_A;
                    end
                end
                ST_MUL_A: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL_B;
                end
                ST_MUL_B: begin
                    tmp_reg   <= prod_reg[2*DIM_W-1:0];
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL_C;
                end
                ST_MUL_C: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    total_reg <= total_reg + TOTAL_W'(prod_reg);
                    cur_w_reg <= cur_w_reg >> 1;
                    cur_h_reg <= cur_h_reg >> 1;
                    cur_d_reg <= cur_d_reg >> 1;
                    lv_reg    <= lv_reg + LEVEL_W'(1);
                    state_reg <= last_level ? ST_FIN_K : ST_LEVEL;
                end
                ST_FIN_K: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_FIN_LO;
                end
                ST_FIN_LO: begin
                    scale_reg <= prod_reg[SCALE_W-1:0];
                    prod_reg  <= mul_p;
                    state_reg <= ST_FIN_HI;
                end
                ST_FIN_HI: begin
                    // low partial product replaces the sum, high one follows
                    total_reg <= TOTAL_W'(prod_reg);
                    prod_reg  <= mul_p;
                    state_reg <= ST_FIN_ADD;
                end
                ST_FIN_ADD: begin
                    total_reg <= total_reg
                               + {prod_reg[TOTAL_W-MUL_A_W-1:0], {MUL_A_W{1'b0}}};
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_DONE);
    assign m_total_bytes = total_reg;

endmodule
